// ===== src/assert_macros.svh =====
// Assertion macros shared by the tilt-to-drive RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge while out of reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion violated");

// Checks that a condition never holds on a rising clock edge while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== src/tdc_pkg.sv =====
// Package with the shared types and constants of the tilt-to-drive block.
`default_nettype none

package tdc_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_RADIUS = 2'd3;

  // Register reset values.
  localparam logic [9:0]  DEAD_ZONE_RST   = 10'd200;
  localparam logic [8:0]  FULL_SPEED_RST  = 9'd500;
  localparam logic [8:0]  SPIN_SPEED_RST  = 9'd250;
  localparam logic [10:0] FULL_RADIUS_RST = 11'd2000;

  // Packet constants.
  localparam logic [7:0]  PKT_TYPE_DRIVE = 8'd11;
  localparam logic [2:0]  PKT_LAST       = 3'd4;
  localparam logic [6:0]  FACTOR_MAX     = 7'd100;
  localparam logic [15:0] STRAIGHT_CODE  = 16'h8000;

  // Depth of the queue between front and back; must be a power of two.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // One input item.
  typedef struct packed {
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last_byte;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [9:0]  dead_zone;
    logic [8:0]  full_speed;
    logic [8:0]  spin_speed;
    logic [10:0] full_radius;
  } cfg_t;

  // Kind of turn that the y factor asks for.
  typedef enum logic [1:0] {
    TURN_STRAIGHT,
    TURN_SPIN,
    TURN_ARC
  } turn_e;

  // Classified command passed from front to back: factors in sign and magnitude.
  typedef struct packed {
    logic       x_neg;
    logic [6:0] x_mag;
    logic       y_neg;
    logic [6:0] y_mag;
    turn_e      turn;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/tilt_to_drive_command.sv =====
// Top level of the tilt-to-drive block: configuration registers and the front, queue and back.
`default_nettype none

// Each accepted tilt sample (x sets speed, y sets turn radius) yields one five-byte drive
// packet: type byte 11, speed high and low, radius high and low, with last_byte set on the
// fifth byte. Bytes leave one per cycle through the result port while pop is held high, and
// the byte sender hands out one byte per pop, so it sets the sustained sample rate. A
// sample passes the input stage, the queue, two scaling stages and the byte sender's hold
// registers before its first byte leaves; the front keeps accepting up to five further
// samples while a packet is still being sent.
// Configuration registers may be written only while no sample is in flight.
module tilt_to_drive_command import tdc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              in_item_i,
  output logic                       empty,
  input  wire logic                  pop,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wr_entry, q_rd_entry;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone   <= DEAD_ZONE_RST;
      cfg_q.full_speed  <= FULL_SPEED_RST;
      cfg_q.spin_speed  <= SPIN_SPEED_RST;
      cfg_q.full_radius <= FULL_RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEAD_ZONE:   cfg_q.dead_zone   <= cfg_data_i[9:0];
        CFG_FULL_SPEED:  cfg_q.full_speed  <= cfg_data_i[8:0];
        CFG_SPIN_SPEED:  cfg_q.spin_speed  <= cfg_data_i[8:0];
        CFG_FULL_RADIUS: cfg_q.full_radius <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: sample intake and classification.
  tdc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .item_i    (in_item_i),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry),
    .q_full_i  (q_full)
  );

  // Command queue between the two halves.
  tdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  // Back end: scaling and packet bytes.
  tdc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_entry_i (q_rd_entry),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .item_o    (out_item_o)
  );

endmodule

`default_nettype wire

// ===== src/tdc_front.sv =====
// Front end: takes tilt samples, computes both axis factors and classifies the turn.
`default_nettype none

module tdc_front import tdc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  output logic          q_push_o,
  output cmd_t          q_entry_o,
  input  wire logic     q_full_i
);

  // Reciprocal of six, exact for excess values up to the scale span.
  localparam logic [15:0] DIV6_RECIP = 16'd43691;
  localparam logic [16:0] SCALE_SPAN = 17'd600;

  // Maps one tilt sample to {sign, magnitude} of its factor in -100..100.
  function automatic logic [7:0] axis_factor(logic signed [15:0] t, logic [9:0] dz);
    logic signed [17:0] ts;
    logic signed [17:0] dzs;
    logic signed [17:0] ex;
    logic [16:0]        m;
    logic [25:0]        prod;
    logic               neg;
    logic               zero;
    logic [6:0]         mag;
    ts   = 18'(t);
    dzs  = $signed({8'd0, dz});
    ex   = '0;
    neg  = 1'b0;
    zero = 1'b0;
    if (ts >= dzs) begin
      ex = ts - dzs;
    end else if (ts <= -dzs) begin
      ex  = -(ts + dzs);
      neg = 1'b1;
    end else begin
      zero = 1'b1;
    end
    m    = ex[16:0];
    prod = 26'(m[9:0]) * 26'(DIV6_RECIP);
    if (zero) begin
      mag = '0;
    end else if (m > SCALE_SPAN) begin
      mag = FACTOR_MAX;
    end else begin
      mag = prod[24:18];
    end
    return {neg, mag};
  endfunction

  logic     stage_v_q, stage_v_d;
  in_item_t stage_q;
  logic     accept;
  logic [7:0] fx, fy;

  // The input stage holds one sample until the queue has room.
  assign full_o   = stage_v_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = stage_v_q && !q_full_i;
  assign stage_v_d = accept || (stage_v_q && q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= item_i;
    end
  end

  // Factor computation and turn classification.
  assign fx = axis_factor(stage_q.tilt_x, cfg_i.dead_zone);
  assign fy = axis_factor(stage_q.tilt_y, cfg_i.dead_zone);

  always_comb begin
    q_entry_o.x_neg = fx[7];
    q_entry_o.x_mag = fx[6:0];
    q_entry_o.y_neg = fy[7];
    q_entry_o.y_mag = fy[6:0];
    if (fy[6:0] == '0) begin
      q_entry_o.turn = TURN_STRAIGHT;
    end else if (fy[6:0] == FACTOR_MAX) begin
      q_entry_o.turn = TURN_SPIN;
    end else begin
      q_entry_o.turn = TURN_ARC;
    end
  end

endmodule

`default_nettype wire

// ===== src/tdc_queue.sv =====
// Short command queue that decouples the front end from the back end.
`default_nettype none
`include "assert_macros.svh"

module tdc_queue import tdc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t entry_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      entry_o,
  output logic      empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Pointers wrap naturally because the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_q_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

`default_nettype wire

// ===== src/tdc_back.sv =====
// Back end: scales the factors into speed and radius and sends the five packet bytes.
`default_nettype none
`include "assert_macros.svh"

module tdc_back import tdc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic q_empty_i,
  input  wire cmd_t q_entry_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_item_t item_o
);

  // Reciprocals of one hundred, exact over the product ranges used here.
  localparam logic [16:0] SPEED_RECIP  = 17'd83887;
  localparam logic [18:0] RADIUS_RECIP = 19'd335545;

  // Byte positions inside the packet.
  localparam logic [2:0] BYTE_TYPE     = 3'd0;
  localparam logic [2:0] BYTE_SPEED_HI = 3'd1;
  localparam logic [2:0] BYTE_SPEED_LO = 3'd2;
  localparam logic [2:0] BYTE_RAD_HI   = 3'd3;
  localparam logic [2:0] BYTE_RAD_LO   = 3'd4;

  logic        s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic        s1_ready, s2_ready;
  cmd_t        s1_cmd_q, s2_cmd_q;
  logic [15:0] s1_ps_q;
  logic [17:0] s1_pr_q;
  logic [8:0]  s2_speed_q;
  logic [10:0] s2_rad_q;
  logic [32:0] prod_s;
  logic [36:0] prod_r;

  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] held_speed_q, held_radius_q;
  logic [15:0] speed_d, radius_d;
  logic [10:0] arc_mag;
  logic        last_pop, load;

  // Handshake between the stages and the byte sender.
  assign last_pop = pop_i && busy_q && (idx_q == PKT_LAST);
  assign load     = s2_v_q && (!busy_q || last_pop);
  assign s2_ready = !s2_v_q || load;
  assign s1_ready = !s1_v_q || s2_ready;
  assign q_pop_o  = s1_ready && !q_empty_i;
  assign s1_v_d   = s1_ready ? q_pop_o : s1_v_q;
  assign s2_v_d   = s2_ready ? s1_v_q : s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  // Stage one: factor times full speed and factor times full radius.
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_cmd_q <= q_entry_i;
      s1_ps_q  <= {9'd0, q_entry_i.x_mag} * {7'd0, cfg_i.full_speed};
      s1_pr_q  <= {11'd0, q_entry_i.y_mag} * {7'd0, cfg_i.full_radius};
    end
  end

  // Stage two: divide both products by one hundred.
  assign prod_s = {17'd0, s1_ps_q} * {16'd0, SPEED_RECIP};
  assign prod_r = {19'd0, s1_pr_q} * {18'd0, RADIUS_RECIP};

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_speed_q <= prod_s[31:23];
      s2_rad_q   <= prod_r[35:25];
    end
  end

  // Final speed and radius with signs applied.
  assign arc_mag = cfg_i.full_radius - s2_rad_q;

  always_comb begin
    speed_d  = s2_cmd_q.x_neg ? 16'd0 - {7'd0, s2_speed_q} : {7'd0, s2_speed_q};
    radius_d = STRAIGHT_CODE;
    unique case (s2_cmd_q.turn)
      TURN_STRAIGHT: begin
        radius_d = STRAIGHT_CODE;
      end
      TURN_SPIN: begin
        radius_d = '0;
        speed_d  = s2_cmd_q.y_neg ? 16'd0 - {7'd0, cfg_i.spin_speed}
                                  : {7'd0, cfg_i.spin_speed};
      end
      TURN_ARC: begin
        radius_d = s2_cmd_q.y_neg ? 16'd0 - {5'd0, arc_mag} : {5'd0, arc_mag};
      end
      default: begin
        radius_d = STRAIGHT_CODE;
      end
    endcase
  end

  // Byte sender: holds one packet and steps through its bytes on each pop.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = BYTE_TYPE;
    end else if (pop_i && busy_q) begin
      if (idx_q == PKT_LAST) begin
        busy_d = 1'b0;
        idx_d  = BYTE_TYPE;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      idx_q         <= BYTE_TYPE;
      held_speed_q  <= '0;
      held_radius_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (load) begin
        held_speed_q  <= speed_d;
        held_radius_q <= radius_d;
      end
    end
  end

  // Result item selection.
  assign empty_o = !busy_q;

  always_comb begin
    item_o.last_byte = (idx_q == PKT_LAST);
    unique case (idx_q)
      BYTE_TYPE:     item_o.cmd_byte = PKT_TYPE_DRIVE;
      BYTE_SPEED_HI: item_o.cmd_byte = held_speed_q[15:8];
      BYTE_SPEED_LO: item_o.cmd_byte = held_speed_q[7:0];
      BYTE_RAD_HI:   item_o.cmd_byte = held_radius_q[15:8];
      BYTE_RAD_LO:   item_o.cmd_byte = held_radius_q[7:0];
      default:       item_o.cmd_byte = PKT_TYPE_DRIVE;
    endcase
  end

  `ASSERT_AT(a_idx_range, clk_i, rst_ni, busy_q |-> (idx_q <= PKT_LAST))
  `ASSERT_AT(a_s2_hold, clk_i, rst_ni, (s2_v_q && !s2_ready) |=> (s2_v_q && $stable(s2_speed_q)))

endmodule

`default_nettype wire
